FILE: rtl/spcot_pkg.sv
// shared types and constants for the segment pair cross and overlap test
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package spcot_pkg;

  // default coordinate width in bits
  localparam int unsigned CoordWidthDefault = 16;

  // number of register stages from input to result
  localparam int unsigned NumStages = 4;

  // endpoint differences between the two segments (point minus point)
  localparam int unsigned EB0A0 = 0;
  localparam int unsigned EB0A1 = 1;
  localparam int unsigned EB1A0 = 2;
  localparam int unsigned EB1A1 = 3;
  localparam int unsigned NumEndDiffs = 4;

  // dot products of the point-on-segment tests
  localparam int unsigned DotA0OnB = 0;
  localparam int unsigned DotA1OnB = 1;
  localparam int unsigned DotB0OnA = 2;
  localparam int unsigned DotB1OnA = 3;
  localparam int unsigned NumDots  = 4;

  // result flags of one segment pair
  typedef struct packed {
    logic crosses;
    logic overlaps;
  } flags_t;

endpackage

`default_nettype wire

FILE: rtl/segment_pair_cross_overlap_test.sv
// top level of the segment pair cross and overlap test
// depends on spcot_pkg, spcot_diff, spcot_prod, spcot_sum and spcot_flag
//
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------
//  in      | in_valid_i, in_stall_o | a_start/a_end/b_start/b_end x and y
//  out     | out_valid_o, out_stall_i | crosses_o, overlaps_o
//
// one segment pair per cycle while out_stall_i is low; each result passes the
// difference, multiply, sum and compare stages after its request is taken.
// reset clears the stage valid bits only. a stalled output holds its result
// and the stages behind it fill up, bubbles close; in_stall_o rises only once
// every stage holds a request.
`timescale 1ns / 1ps
`default_nettype none

module segment_pair_cross_overlap_test
  import spcot_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = CoordWidthDefault
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_stall_o,
  input  wire  signed [COORD_WIDTH-1:0]  a_start_x_i,
  input  wire  signed [COORD_WIDTH-1:0]  a_start_y_i,
  input  wire  signed [COORD_WIDTH-1:0]  a_end_x_i,
  input  wire  signed [COORD_WIDTH-1:0]  a_end_y_i,
  input  wire  signed [COORD_WIDTH-1:0]  b_start_x_i,
  input  wire  signed [COORD_WIDTH-1:0]  b_start_y_i,
  input  wire  signed [COORD_WIDTH-1:0]  b_end_x_i,
  input  wire  signed [COORD_WIDTH-1:0]  b_end_y_i,
  output logic                           out_valid_o,
  input  wire                            out_stall_i,
  output logic                           crosses_o,
  output logic                           overlaps_o
);

  localparam int unsigned DW = COORD_WIDTH + 1;
  localparam int unsigned PW = 2 * COORD_WIDTH + 2;
  localparam int unsigned SW = 2 * COORD_WIDTH + 3;

  logic [NumStages-1:0] valid_q, valid_d, ready, load;

  logic signed [DW-1:0] da_x, da_y, db_x, db_y;
  logic signed [DW-1:0] e_x [NumEndDiffs];
  logic signed [DW-1:0] e_y [NumEndDiffs];

  logic signed [PW-1:0] d_pos, d_neg, nt_pos, nt_neg, nu_pos, nu_neg;
  logic signed [PW-1:0] dot_x [NumDots];
  logic signed [PW-1:0] dot_y [NumDots];

  logic signed [SW-1:0] d_sum, nt_sum, nu_sum;
  logic signed [SW-1:0] dot_sum [NumDots];

  flags_t flags;

  // a stage may take new data when it is empty or its content moves on
  always_comb begin
    ready[3] = !valid_q[3] || !out_stall_i;
    ready[2] = !valid_q[2] || ready[3];
    ready[1] = !valid_q[1] || ready[2];
    ready[0] = !valid_q[0] || ready[1];
  end

  // data registers load only for a valid request moving in
  assign load[0] = ready[0] && in_valid_i;
  assign load[1] = ready[1] && valid_q[0];
  assign load[2] = ready[2] && valid_q[1];
  assign load[3] = ready[3] && valid_q[2];

  // valid bits travel with the data
  always_comb begin
    valid_d[0] = ready[0] ? in_valid_i : valid_q[0];
    valid_d[1] = ready[1] ? valid_q[0] : valid_q[1];
    valid_d[2] = ready[2] ? valid_q[1] : valid_q[2];
    valid_d[3] = ready[3] ? valid_q[2] : valid_q[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_stall_o  = !ready[0];
  assign out_valid_o = valid_q[3];
  assign crosses_o   = flags.crosses;
  assign overlaps_o  = flags.overlaps;

  // stage one: differences
  spcot_diff #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_diff (
    .clk_i      (clk_i),
    .load_i     (load[0]),
    .a_start_x_i(a_start_x_i),
    .a_start_y_i(a_start_y_i),
    .a_end_x_i  (a_end_x_i),
    .a_end_y_i  (a_end_y_i),
    .b_start_x_i(b_start_x_i),
    .b_start_y_i(b_start_y_i),
    .b_end_x_i  (b_end_x_i),
    .b_end_y_i  (b_end_y_i),
    .da_x_o     (da_x),
    .da_y_o     (da_y),
    .db_x_o     (db_x),
    .db_y_o     (db_y),
    .e_x_o      (e_x),
    .e_y_o      (e_y)
  );

  // stage two: products
  spcot_prod #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_prod (
    .clk_i   (clk_i),
    .load_i  (load[1]),
    .da_x_i  (da_x),
    .da_y_i  (da_y),
    .db_x_i  (db_x),
    .db_y_i  (db_y),
    .e_x_i   (e_x),
    .e_y_i   (e_y),
    .d_pos_o (d_pos),
    .d_neg_o (d_neg),
    .nt_pos_o(nt_pos),
    .nt_neg_o(nt_neg),
    .nu_pos_o(nu_pos),
    .nu_neg_o(nu_neg),
    .dot_x_o (dot_x),
    .dot_y_o (dot_y)
  );

  // stage three: cross and dot products
  spcot_sum #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_sum (
    .clk_i   (clk_i),
    .load_i  (load[2]),
    .d_pos_i (d_pos),
    .d_neg_i (d_neg),
    .nt_pos_i(nt_pos),
    .nt_neg_i(nt_neg),
    .nu_pos_i(nu_pos),
    .nu_neg_i(nu_neg),
    .dot_x_i (dot_x),
    .dot_y_i (dot_y),
    .d_o     (d_sum),
    .nt_o    (nt_sum),
    .nu_o    (nu_sum),
    .dot_o   (dot_sum)
  );

  // stage four: flags into the output register
  spcot_flag #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_flag (
    .clk_i  (clk_i),
    .load_i (load[3]),
    .d_i    (d_sum),
    .nt_i   (nt_sum),
    .nu_i   (nu_sum),
    .dot_i  (dot_sum),
    .flags_o(flags)
  );

  // the two flags come from exclusive determinant cases
  a_flags_exclusive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(crosses_o && overlaps_o))
    else $error("crosses and overlaps both set");

  // input is held back only when every stage is occupied
  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (valid_q == '1))
    else $error("input stalled with an empty stage");

  // a taken request occupies the first stage at the next edge
  a_take_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> valid_q[0])
    else $error("accepted request lost in first stage");

endmodule

`default_nettype wire

FILE: rtl/spcot_diff.sv
// stage one: sign-extended coordinate differences of both segments
// depends on spcot_pkg
`timescale 1ns / 1ps
`default_nettype none

module spcot_diff
  import spcot_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = CoordWidthDefault
) (
  input  wire                            clk_i,
  input  wire                            load_i,
  input  wire  signed [COORD_WIDTH-1:0]  a_start_x_i,
  input  wire  signed [COORD_WIDTH-1:0]  a_start_y_i,
  input  wire  signed [COORD_WIDTH-1:0]  a_end_x_i,
  input  wire  signed [COORD_WIDTH-1:0]  a_end_y_i,
  input  wire  signed [COORD_WIDTH-1:0]  b_start_x_i,
  input  wire  signed [COORD_WIDTH-1:0]  b_start_y_i,
  input  wire  signed [COORD_WIDTH-1:0]  b_end_x_i,
  input  wire  signed [COORD_WIDTH-1:0]  b_end_y_i,
  output logic signed [COORD_WIDTH:0]    da_x_o,
  output logic signed [COORD_WIDTH:0]    da_y_o,
  output logic signed [COORD_WIDTH:0]    db_x_o,
  output logic signed [COORD_WIDTH:0]    db_y_o,
  output logic signed [COORD_WIDTH:0]    e_x_o [NumEndDiffs],
  output logic signed [COORD_WIDTH:0]    e_y_o [NumEndDiffs]
);

  localparam int unsigned DW = COORD_WIDTH + 1;

  logic signed [DW-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;

  // sign extension by one bit so that every difference fits
  assign ax0 = DW'(a_start_x_i);
  assign ay0 = DW'(a_start_y_i);
  assign ax1 = DW'(a_end_x_i);
  assign ay1 = DW'(a_end_y_i);
  assign bx0 = DW'(b_start_x_i);
  assign by0 = DW'(b_start_y_i);
  assign bx1 = DW'(b_end_x_i);
  assign by1 = DW'(b_end_y_i);

  // direction vectors and endpoint-to-endpoint differences
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      da_x_o        <= ax1 - ax0;
      da_y_o        <= ay1 - ay0;
      db_x_o        <= bx1 - bx0;
      db_y_o        <= by1 - by0;
      e_x_o[EB0A0]  <= bx0 - ax0;
      e_y_o[EB0A0]  <= by0 - ay0;
      e_x_o[EB0A1]  <= bx0 - ax1;
      e_y_o[EB0A1]  <= by0 - ay1;
      e_x_o[EB1A0]  <= bx1 - ax0;
      e_y_o[EB1A0]  <= by1 - ay0;
      e_x_o[EB1A1]  <= bx1 - ax1;
      e_y_o[EB1A1]  <= by1 - ay1;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/spcot_prod.sv
// stage two: all products for the cross and dot products, one register each
// depends on spcot_pkg
`timescale 1ns / 1ps
`default_nettype none

module spcot_prod
  import spcot_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = CoordWidthDefault
) (
  input  wire                              clk_i,
  input  wire                              load_i,
  input  wire  signed [COORD_WIDTH:0]      da_x_i,
  input  wire  signed [COORD_WIDTH:0]      da_y_i,
  input  wire  signed [COORD_WIDTH:0]      db_x_i,
  input  wire  signed [COORD_WIDTH:0]      db_y_i,
  input  wire  signed [COORD_WIDTH:0]      e_x_i [NumEndDiffs],
  input  wire  signed [COORD_WIDTH:0]      e_y_i [NumEndDiffs],
  output logic signed [2*COORD_WIDTH+1:0]  d_pos_o,
  output logic signed [2*COORD_WIDTH+1:0]  d_neg_o,
  output logic signed [2*COORD_WIDTH+1:0]  nt_pos_o,
  output logic signed [2*COORD_WIDTH+1:0]  nt_neg_o,
  output logic signed [2*COORD_WIDTH+1:0]  nu_pos_o,
  output logic signed [2*COORD_WIDTH+1:0]  nu_neg_o,
  output logic signed [2*COORD_WIDTH+1:0]  dot_x_o [NumDots],
  output logic signed [2*COORD_WIDTH+1:0]  dot_y_o [NumDots]
);

  localparam int unsigned PW = 2 * COORD_WIDTH + 2;

  // w is the vector from the start of a to the start of b
  logic signed [COORD_WIDTH:0] w_x, w_y;

  assign w_x = e_x_i[EB0A0];
  assign w_y = e_y_i[EB0A0];

  // cross product terms: d = da x db, nt = w x db, nu = w x da
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      d_pos_o  <= PW'(da_x_i) * PW'(db_y_i);
      d_neg_o  <= PW'(da_y_i) * PW'(db_x_i);
      nt_pos_o <= PW'(w_x) * PW'(db_y_i);
      nt_neg_o <= PW'(w_y) * PW'(db_x_i);
      nu_pos_o <= PW'(w_x) * PW'(da_y_i);
      nu_neg_o <= PW'(w_y) * PW'(da_x_i);
    end
  end

  // dot product terms of the four point-on-segment tests
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      dot_x_o[DotA0OnB] <= PW'(e_x_i[EB0A0]) * PW'(e_x_i[EB1A0]);
      dot_y_o[DotA0OnB] <= PW'(e_y_i[EB0A0]) * PW'(e_y_i[EB1A0]);
      dot_x_o[DotA1OnB] <= PW'(e_x_i[EB0A1]) * PW'(e_x_i[EB1A1]);
      dot_y_o[DotA1OnB] <= PW'(e_y_i[EB0A1]) * PW'(e_y_i[EB1A1]);
      dot_x_o[DotB0OnA] <= PW'(e_x_i[EB0A0]) * PW'(e_x_i[EB0A1]);
      dot_y_o[DotB0OnA] <= PW'(e_y_i[EB0A0]) * PW'(e_y_i[EB0A1]);
      dot_x_o[DotB1OnA] <= PW'(e_x_i[EB1A0]) * PW'(e_x_i[EB1A1]);
      dot_y_o[DotB1OnA] <= PW'(e_y_i[EB1A0]) * PW'(e_y_i[EB1A1]);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/spcot_sum.sv
// stage three: combines product pairs into cross and dot products
// depends on spcot_pkg
`timescale 1ns / 1ps
`default_nettype none

module spcot_sum
  import spcot_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = CoordWidthDefault
) (
  input  wire                              clk_i,
  input  wire                              load_i,
  input  wire  signed [2*COORD_WIDTH+1:0]  d_pos_i,
  input  wire  signed [2*COORD_WIDTH+1:0]  d_neg_i,
  input  wire  signed [2*COORD_WIDTH+1:0]  nt_pos_i,
  input  wire  signed [2*COORD_WIDTH+1:0]  nt_neg_i,
  input  wire  signed [2*COORD_WIDTH+1:0]  nu_pos_i,
  input  wire  signed [2*COORD_WIDTH+1:0]  nu_neg_i,
  input  wire  signed [2*COORD_WIDTH+1:0]  dot_x_i [NumDots],
  input  wire  signed [2*COORD_WIDTH+1:0]  dot_y_i [NumDots],
  output logic signed [2*COORD_WIDTH+2:0]  d_o,
  output logic signed [2*COORD_WIDTH+2:0]  nt_o,
  output logic signed [2*COORD_WIDTH+2:0]  nu_o,
  output logic signed [2*COORD_WIDTH+2:0]  dot_o [NumDots]
);

  localparam int unsigned SW = 2 * COORD_WIDTH + 3;

  // cross products
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      d_o  <= SW'(d_pos_i) - SW'(d_neg_i);
      nt_o <= SW'(nt_pos_i) - SW'(nt_neg_i);
      nu_o <= SW'(nu_pos_i) - SW'(nu_neg_i);
    end
  end

  // dot products, each lane on its own
  for (genvar g = 0; g < NumDots; g++) begin : g_dot
    always_ff @(posedge clk_i) begin
      if (load_i) begin
        dot_o[g] <= SW'(dot_x_i[g]) + SW'(dot_y_i[g]);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/spcot_flag.sv
// stage four: bounds compares and collinear overlap decision, output register
// depends on spcot_pkg (flags_t)
`timescale 1ns / 1ps
`default_nettype none

module spcot_flag
  import spcot_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = CoordWidthDefault
) (
  input  wire                              clk_i,
  input  wire                              load_i,
  input  wire  signed [2*COORD_WIDTH+2:0]  d_i,
  input  wire  signed [2*COORD_WIDTH+2:0]  nt_i,
  input  wire  signed [2*COORD_WIDTH+2:0]  nu_i,
  input  wire  signed [2*COORD_WIDTH+2:0]  dot_i [NumDots],
  output flags_t                           flags_o
);

  localparam int unsigned SW = 2 * COORD_WIDTH + 3;

  logic   d_zero, d_neg, nt_zero, nu_zero, any_on;
  logic   cross_pos, cross_neg;
  flags_t flags_d;

  assign d_zero  = (d_i == '0);
  assign d_neg   = d_i[SW-1];
  assign nt_zero = (nt_i == '0);
  assign nu_zero = (nu_i == '0);

  // intersection strictly inside a and on b (ends of b included), for either sign of the determinant
  assign cross_pos = (nt_i > 0) && (nt_i < d_i) && (nu_i >= 0) && (nu_i <= d_i);
  assign cross_neg = (nt_i < 0) && (nt_i > d_i) && (nu_i <= 0) && (nu_i >= d_i);

  // some endpoint lies between the ends of the other segment
  always_comb begin
    any_on = 1'b0;
    for (int k = 0; k < NumDots; k++) begin
      any_on = any_on | (dot_i[k] <= 0);
    end
  end

  // final flags
  always_comb begin
    flags_d.crosses  = !d_zero && (d_neg ? cross_neg : cross_pos);
    flags_d.overlaps = d_zero && nt_zero && nu_zero && any_on;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      flags_o <= flags_d;
    end
  end

endmodule

`default_nettype wire
